>>> design/five_channel_modulator_levels_defines.svh
// Assertion macros shared by the modulator level block.
// Depends on nothing; included by the files that carry assertions.
`ifndef FIVE_CHANNEL_MODULATOR_LEVELS_DEFINES_SVH
`define FIVE_CHANNEL_MODULATOR_LEVELS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCML_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FCML_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fcml_pkg.sv
// Types, constants and helper functions of the modulator level block.
// Used by fcml_ctrl, fcml_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package fcml_pkg;

  localparam int CHANNELS    = 5;
  localparam int CH_W        = 3;
  localparam int LEVEL_W     = 16;
  localparam int MUL_A_W     = 16;
  localparam int MUL_B_W     = 20;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int NUM_W       = PROD_W + 3;
  localparam int REM_W       = 29;
  localparam int RECIP_W     = 30;
  localparam int QPROD_W     = REM_W + RECIP_W;
  localparam int RECIP_SHIFT = 43;

  localparam logic [LEVEL_W-1:0] ONE_Q15        = 16'd32768;
  localparam logic [LEVEL_W-1:0] BASELINE_RESET = 16'd16384;
  localparam logic [LEVEL_W-1:0] GAIN_RESET     = 16'd6554;
  localparam logic [LEVEL_W-1:0] RATE_RESET     = 16'd410;
  localparam logic [LEVEL_W-1:0] MARGIN_RESET   = 16'd9830;

  localparam logic [PROD_W-1:0] ROUND_HALF     = 36'd16384;
  localparam logic [NUM_W-1:0]  TICK_BIAS      = 39'd500000;
  localparam logic [NUM_W-1:0]  TICK_SAT_LIMIT = 39'd32769000000;
  // 2^43 / 15625 rounded up; exact for every dividend below 2^29.
  localparam logic [RECIP_W-1:0] TICK_RECIP    = 30'd562949954;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_GAIN   = 3'd5;
  localparam logic [2:0] REG_RATE   = 3'd6;
  localparam logic [2:0] REG_MARGIN = 3'd7;

  // Motive codes.
  localparam logic [2:0] MOT_NEUTRAL  = 3'd0;
  localparam logic [2:0] MOT_APPROACH = 3'd1;
  localparam logic [2:0] MOT_AVOID    = 3'd2;
  localparam logic [2:0] MOT_ALERT    = 3'd3;
  localparam logic [2:0] MOT_FATIGUED = 3'd4;
  localparam logic [2:0] MOT_FOCUSED  = 3'd5;

  typedef enum logic [1:0] {
    FUNC_SET     = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_PAUSE   = 2'd2,
    FUNC_TICK    = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_STEP_MUL,
    S_STEP_APPLY,
    S_TICK_MUL,
    S_TICK_PREP,
    S_DIV,
    S_DECAY_MUL,
    S_DECAY_UPD,
    S_MOTIVE,
    S_FINISH
  } state_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LATCH,
    DP_EXEC,
    DP_STEP_MUL,
    DP_STEP_APPLY,
    DP_TICK_MUL,
    DP_TICK_PREP,
    DP_DIV,
    DP_DECAY_MUL,
    DP_DECAY_UPD,
    DP_MOTIVE,
    DP_LOAD_OUT
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [CH_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic is_step;
    logic is_tick;
    logic ch_ok;
    logic dt_zero;
    logic tick_sat;
    logic out_free;
  } dp_status_t;

  function automatic logic [LEVEL_W-1:0] sat_one(input logic [LEVEL_W-1:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

>>> design/fcml_ctrl.sv
// Sequencer of the modulator level block: steps the datapath through
// each transfer. Depends on fcml_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "five_channel_modulator_levels_defines.svh"

module fcml_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fcml_pkg::dp_status_t sts_i,
  output fcml_pkg::cmd_t      cmd_o
);

  fcml_pkg::state_e state_q, state_d;
  logic [fcml_pkg::CH_W-1:0]      ch_q, ch_d;

  localparam logic [fcml_pkg::CH_W-1:0] LAST_CH = 3'(fcml_pkg::CHANNELS - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      fcml_pkg::S_IDLE: begin
        if (in_valid_i) state_d = fcml_pkg::S_EXEC;
      end
      fcml_pkg::S_EXEC: begin
        if (sts_i.is_step && sts_i.ch_ok) begin
          state_d = fcml_pkg::S_STEP_MUL;
        end else if (sts_i.is_tick && !sts_i.dt_zero) begin
          state_d = fcml_pkg::S_TICK_MUL;
        end else begin
          state_d = fcml_pkg::S_FINISH;
        end
      end
      fcml_pkg::S_STEP_MUL:   state_d = fcml_pkg::S_STEP_APPLY;
      fcml_pkg::S_STEP_APPLY: state_d = fcml_pkg::S_FINISH;
      fcml_pkg::S_TICK_MUL:   state_d = fcml_pkg::S_TICK_PREP;
      fcml_pkg::S_TICK_PREP: begin
        state_d = sts_i.tick_sat ? fcml_pkg::S_DECAY_MUL : fcml_pkg::S_DIV;
      end
      fcml_pkg::S_DIV:       state_d = fcml_pkg::S_DECAY_MUL;
      fcml_pkg::S_DECAY_MUL: state_d = fcml_pkg::S_DECAY_UPD;
      fcml_pkg::S_DECAY_UPD: begin
        state_d = (ch_q == LAST_CH) ? fcml_pkg::S_MOTIVE : fcml_pkg::S_DECAY_MUL;
      end
      fcml_pkg::S_MOTIVE: state_d = fcml_pkg::S_FINISH;
      fcml_pkg::S_FINISH: begin
        if (sts_i.out_free) state_d = fcml_pkg::S_IDLE;
      end
      default: state_d = fcml_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ch_d = ch_q;
    if (state_q == fcml_pkg::S_TICK_PREP) begin
      ch_d = '0;
    end else if (state_q == fcml_pkg::S_DECAY_UPD) begin
      ch_d = ch_q + 1'b1;
    end
  end

  always_comb begin
    cmd_o.ch  = ch_q;
    in_stall_o = (state_q != fcml_pkg::S_IDLE);
    case (state_q)
      fcml_pkg::S_IDLE:       cmd_o.op = in_valid_i ? fcml_pkg::DP_LATCH : fcml_pkg::DP_NONE;
      fcml_pkg::S_EXEC:       cmd_o.op = fcml_pkg::DP_EXEC;
      fcml_pkg::S_STEP_MUL:   cmd_o.op = fcml_pkg::DP_STEP_MUL;
      fcml_pkg::S_STEP_APPLY: cmd_o.op = fcml_pkg::DP_STEP_APPLY;
      fcml_pkg::S_TICK_MUL:   cmd_o.op = fcml_pkg::DP_TICK_MUL;
      fcml_pkg::S_TICK_PREP:  cmd_o.op = fcml_pkg::DP_TICK_PREP;
      fcml_pkg::S_DIV:        cmd_o.op = fcml_pkg::DP_DIV;
      fcml_pkg::S_DECAY_MUL:  cmd_o.op = fcml_pkg::DP_DECAY_MUL;
      fcml_pkg::S_DECAY_UPD:  cmd_o.op = fcml_pkg::DP_DECAY_UPD;
      fcml_pkg::S_MOTIVE:     cmd_o.op = fcml_pkg::DP_MOTIVE;
      fcml_pkg::S_FINISH: begin
        cmd_o.op = sts_i.out_free ? fcml_pkg::DP_LOAD_OUT : fcml_pkg::DP_NONE;
      end
      default:                cmd_o.op = fcml_pkg::DP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcml_pkg::S_IDLE;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  `FCML_ASSERT_NEXT(a_accept_to_exec, clk_i, rst_ni, state_q == fcml_pkg::S_IDLE && in_valid_i, state_q == fcml_pkg::S_EXEC, "accepted transfer did not start execution")
  `FCML_ASSERT_NEXT(a_div_to_decay, clk_i, rst_ni, state_q == fcml_pkg::S_DIV, state_q == fcml_pkg::S_DECAY_MUL && ch_q == '0, "division did not hand over to channel zero")
  `FCML_ASSERT_NEXT(a_decay_to_motive, clk_i, rst_ni, state_q == fcml_pkg::S_DECAY_UPD && ch_q == LAST_CH, state_q == fcml_pkg::S_MOTIVE, "decay sweep did not end after the last channel")

endmodule

>>> design/fcml_dp.sv
// Datapath of the modulator level block: configuration registers, levels,
// shared multiplier, tick-factor reciprocal multiplier and output register. Uses fcml_pkg.
`timescale 1ns / 1ps
`include "five_channel_modulator_levels_defines.svh"

module fcml_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic [1:0]          func_i,
  input  logic [2:0]          channel_i,
  input  logic signed [16:0]  amount_i,
  input  logic [19:0]         time_step_i,
  input  fcml_pkg::cmd_t      cmd_i,
  output fcml_pkg::dp_status_t sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                status_o,
  output logic [2:0]          motive_o,
  output logic [15:0]         level_o [fcml_pkg::CHANNELS]
);

  localparam int LW = fcml_pkg::LEVEL_W;
  localparam int N  = fcml_pkg::CHANNELS;

  // Configuration.
  logic [LW-1:0] baseline_q [N];
  logic [LW-1:0] gain_q, rate_q, margin_q;

  // Item operands.
  fcml_pkg::func_e             func_q;
  logic [fcml_pkg::CH_W-1:0]   ch_q;
  logic [LW-1:0]               amt_q;
  logic [19:0]                 dt_q;

  // Working registers.
  logic [fcml_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [fcml_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [LW-1:0]               factor_q, factor_d;
  logic                        dir_q, dir_d;

  // Block state.
  logic [LW-1:0] levels_q [N];
  logic [LW-1:0] levels_d [N];
  logic [2:0]    motive_q, motive_d;
  logic          status_q, status_d;

  // Output register.
  logic          out_valid_q;
  logic          out_status_q;
  logic [2:0]    out_motive_q;
  logic [LW-1:0] out_level_q [N];

  logic [LW-1:0] amt_clamped;
  logic          ch_ok;
  logic [fcml_pkg::CH_W-1:0] rd_idx;
  logic          rd_ok;
  logic [LW-1:0] lvl_rd, base_rd, diff;
  logic [fcml_pkg::MUL_A_W-1:0] mul_a;
  logic [fcml_pkg::MUL_B_W-1:0] mul_b;
  logic [fcml_pkg::PROD_W-1:0]  mul_p, prod_rnd;
  logic [LW-1:0] rnd_step;
  logic [LW:0]   step_sum;
  logic [fcml_pkg::NUM_W-1:0] tick_num;
  logic [fcml_pkg::QPROD_W-1:0] div_prod;
  logic [N-1:0]  above;
  logic [2:0]    motive_new;
  logic          levels_ok;

  // Negative amounts read as zero and anything above one as one.
  always_comb begin
    if (amount_i[16]) begin
      amt_clamped = '0;
    end else begin
      amt_clamped = fcml_pkg::sat_one(amount_i[15:0]);
    end
  end

  assign ch_ok  = (ch_q < 3'(N));
  assign rd_idx = (cmd_i.op == fcml_pkg::DP_EXEC || cmd_i.op == fcml_pkg::DP_STEP_APPLY) ?
                  ch_q : cmd_i.ch;
  assign rd_ok  = (rd_idx < 3'(N));

  always_comb begin
    lvl_rd  = '0;
    base_rd = '0;
    if (rd_ok) begin
      lvl_rd  = levels_q[rd_idx];
      base_rd = fcml_pkg::sat_one(baseline_q[rd_idx]);
    end
  end

  assign diff = (base_rd >= lvl_rd) ? (base_rd - lvl_rd) : (lvl_rd - base_rd);

  // One shared multiplier; its product is registered into prod_q in the multiply steps.
  always_comb begin
    case (cmd_i.op)
      fcml_pkg::DP_STEP_MUL: begin
        mul_a = amt_q;
        mul_b = {4'b0, fcml_pkg::sat_one(gain_q)};
      end
      fcml_pkg::DP_TICK_MUL: begin
        mul_a = rate_q;
        mul_b = dt_q;
      end
      default: begin
        mul_a = diff;
        mul_b = {4'b0, factor_q};
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Products here never exceed 2^30, so bits 30:15 hold the rounded result.
  assign prod_rnd = prod_q + fcml_pkg::ROUND_HALF;
  assign rnd_step = prod_rnd[30:15];
  assign step_sum = {1'b0, lvl_rd} + {1'b0, rnd_step};

  // One million is 64 times 15625: the numerator drops six bits and the
  // division by 15625 becomes a multiplication by a scaled reciprocal.
  assign tick_num = {prod_q, 3'b000} + fcml_pkg::TICK_BIAS;
  assign div_prod = rem_q * fcml_pkg::TICK_RECIP;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      above[i] = ({1'b0, levels_q[i]} >
                  ({1'b0, fcml_pkg::sat_one(baseline_q[i])} + {1'b0, margin_q}));
    end
    // Lowest priority first so that higher priorities override.
    motive_new = fcml_pkg::MOT_NEUTRAL;
    if (above[2]) motive_new = fcml_pkg::MOT_FOCUSED;
    if (above[4]) motive_new = fcml_pkg::MOT_FATIGUED;
    if (above[3]) motive_new = fcml_pkg::MOT_ALERT;
    if (above[1]) motive_new = fcml_pkg::MOT_AVOID;
    if (above[0]) motive_new = fcml_pkg::MOT_APPROACH;
  end

  always_comb begin
    levels_d = levels_q;
    motive_d = motive_q;
    status_d = status_q;
    prod_d   = prod_q;
    rem_d    = rem_q;
    factor_d = factor_q;
    dir_d    = dir_q;
    case (cmd_i.op)
      fcml_pkg::DP_EXEC: begin
        status_d = ((func_q == fcml_pkg::FUNC_SET) && !ch_ok) ||
                   ((func_q == fcml_pkg::FUNC_TICK) && (dt_q == '0));
        if (func_q == fcml_pkg::FUNC_SET && rd_ok) levels_d[rd_idx] = amt_q;
      end
      fcml_pkg::DP_STEP_MUL, fcml_pkg::DP_TICK_MUL: begin
        prod_d = mul_p;
      end
      fcml_pkg::DP_STEP_APPLY: begin
        if (rd_ok) begin
          if (func_q == fcml_pkg::FUNC_RELEASE) begin
            levels_d[rd_idx] = (step_sum > {1'b0, fcml_pkg::ONE_Q15}) ?
                               fcml_pkg::ONE_Q15 : step_sum[LW-1:0];
          end else begin
            levels_d[rd_idx] = (lvl_rd > rnd_step) ? (lvl_rd - rnd_step) : '0;
          end
        end
      end
      fcml_pkg::DP_TICK_PREP: begin
        rem_d    = tick_num[6 +: fcml_pkg::REM_W];
        factor_d = (tick_num >= fcml_pkg::TICK_SAT_LIMIT) ? fcml_pkg::ONE_Q15 : '0;
      end
      fcml_pkg::DP_DIV: begin
        factor_d = div_prod[fcml_pkg::RECIP_SHIFT +: LW];
      end
      fcml_pkg::DP_DECAY_MUL: begin
        prod_d = mul_p;
        dir_d  = (base_rd >= lvl_rd);
      end
      fcml_pkg::DP_DECAY_UPD: begin
        if (rd_ok) begin
          levels_d[rd_idx] = dir_q ? (lvl_rd + rnd_step) : (lvl_rd - rnd_step);
        end
      end
      fcml_pkg::DP_MOTIVE: begin
        motive_d = motive_new;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        baseline_q[i] <= fcml_pkg::BASELINE_RESET;
      end
      gain_q   <= fcml_pkg::GAIN_RESET;
      rate_q   <= fcml_pkg::RATE_RESET;
      margin_q <= fcml_pkg::MARGIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fcml_pkg::REG_GAIN:   gain_q   <= cfg_wdata_i;
        fcml_pkg::REG_RATE:   rate_q   <= cfg_wdata_i;
        fcml_pkg::REG_MARGIN: margin_q <= cfg_wdata_i;
        default: begin
          if (cfg_idx_i < 3'(N)) baseline_q[cfg_idx_i] <= cfg_wdata_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        levels_q[i] <= fcml_pkg::sat_one(fcml_pkg::BASELINE_RESET);
      end
      motive_q    <= fcml_pkg::MOT_NEUTRAL;
      status_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      levels_q <= levels_d;
      motive_q <= motive_d;
      status_q <= status_d;
      if (cmd_i.op == fcml_pkg::DP_LOAD_OUT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    factor_q <= factor_d;
    dir_q    <= dir_d;
    if (cmd_i.op == fcml_pkg::DP_LATCH) begin
      func_q <= fcml_pkg::func_e'(func_i);
      ch_q   <= channel_i;
      amt_q  <= amt_clamped;
      dt_q   <= time_step_i;
    end
    if (cmd_i.op == fcml_pkg::DP_LOAD_OUT) begin
      out_status_q <= status_q;
      out_motive_q <= motive_q;
      out_level_q  <= levels_q;
    end
  end

  always_comb begin
    sts_o.is_step  = (func_q == fcml_pkg::FUNC_RELEASE) || (func_q == fcml_pkg::FUNC_PAUSE);
    sts_o.is_tick  = (func_q == fcml_pkg::FUNC_TICK);
    sts_o.ch_ok    = ch_ok;
    sts_o.dt_zero  = (dt_q == '0);
    sts_o.tick_sat = (tick_num >= fcml_pkg::TICK_SAT_LIMIT);
    sts_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign motive_o    = out_motive_q;
  assign level_o     = out_level_q;

  always_comb begin
    levels_ok = 1'b1;
    for (int i = 0; i < N; i++) begin
      if (levels_q[i] > fcml_pkg::ONE_Q15) levels_ok = 1'b0;
    end
  end

  `FCML_ASSERT_NOW(a_levels_in_range, clk_i, rst_ni, 1'b1, levels_ok, "a level left the range zero to one")
  `FCML_ASSERT_NOW(a_out_rise_loaded, clk_i, rst_ni, $rose(out_valid_q), $past(cmd_i.op == fcml_pkg::DP_LOAD_OUT), "output valid rose without a load")
  `FCML_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && out_stall_i, out_valid_q && $stable(out_status_q) && $stable(out_motive_q), "stalled result changed")

endmodule

>>> design/five_channel_modulator_levels.sv
// Five-channel modulator level block.
//
// Input channel: func_i, channel_i, amount_i, time_step_i, transferred on a
// rising edge with in_valid_i high and in_stall_o low. Output channel: status_o,
// motive_o and the five level ports, transferred with out_valid_o high and
// out_stall_i low. Configuration: cfg_we_i writes cfg_wdata_i to register
// cfg_idx_i at once; write only while the block is idle.
//
// Items are processed one at a time. A set completes in its execute step, a
// release or pause in a gain multiply and an apply step. A tick turns rate
// times tick length into the decay factor with a reciprocal multiplication,
// which is skipped when the decay factor saturates, and then takes each
// channel through a multiply and an update step in the shared multiplier.
// The input is free again in the cycle in which the result turns valid.
// A stalled result holds in the output register while the next item is
// taken and worked on; that item finishes only once the register drains.
// Reset restores the configuration registers to their reset values, the
// levels to their reset baselines and the motive to neutral.
`timescale 1ns / 1ps

module five_channel_modulator_levels (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [2:0]         channel_i,
  input  logic signed [16:0] amount_i,
  input  logic [19:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic [2:0]         motive_o,
  output logic [15:0]        level_dopamine_o,
  output logic [15:0]        level_serotonin_o,
  output logic [15:0]        level_acetylcholine_o,
  output logic [15:0]        level_norepinephrine_o,
  output logic [15:0]        level_adenosine_o
);

  fcml_pkg::cmd_t       cmd;
  fcml_pkg::dp_status_t sts;
  logic [15:0]          level [fcml_pkg::CHANNELS];

  fcml_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fcml_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .func_i      (func_i),
    .channel_i   (channel_i),
    .amount_i    (amount_i),
    .time_step_i (time_step_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .motive_o    (motive_o),
    .level_o     (level)
  );

  assign level_dopamine_o       = level[0];
  assign level_serotonin_o      = level[1];
  assign level_acetylcholine_o  = level[2];
  assign level_norepinephrine_o = level[3];
  assign level_adenosine_o      = level[4];

endmodule
